>>> sv/trle_pkg.sv
// ----------------------------------------------------------------------------
// trle_pkg: shared types and constants of the TGA RLE pixel decoder.
// Holds the phase and controller state types, result kinds, error codes and
// the command and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package trle_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_ID     = 3'd1,
    PH_PKT    = 3'd2,
    PH_PIX    = 3'd3,
    PH_DONE   = 3'd4,
    PH_ERR    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_EXEC,
    C_ROUTE,
    C_EMIT_RUN,
    C_WRAP,
    C_EMIT_TAIL
  } ctrl_state_t;

  localparam logic [1:0] KIND_RUN      = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_SHORT_HDR   = 3'd1;
  localparam logic [2:0] ERR_UNSUPPORTED = 3'd2;
  localparam logic [2:0] ERR_BUDGET      = 3'd3;
  localparam logic [2:0] ERR_SHORT_ID    = 3'd4;
  localparam logic [2:0] ERR_SHORT_PKT   = 3'd5;
  localparam logic [2:0] ERR_PKT_BOUNDS  = 3'd6;

  localparam logic [0:0] REG_BUDGET   = 1'b0;
  localparam logic [0:0] REG_DATA_END = 1'b1;

  localparam int HeaderLen   = 18;
  localparam int OutDataBits = 96;

  localparam logic [7:0] TYPE_RAW = 8'd2;
  localparam logic [7:0] TYPE_RLE = 8'd10;

  typedef struct packed {
    logic take;
    logic exec;
    logic load_run;
    logic load_tail;
    logic wrap_start;
  } trle_cmd_t;

  typedef struct packed {
    logic has_run;
    logic has_tail;
    logic need_wrap;
    logic wrap_done;
    logic out_free;
  } trle_status_t;

endpackage

>>> sv/trle_wrap.sv
// ----------------------------------------------------------------------------
// trle_wrap: advances the pixel position by one run.
// Divides column plus run length by the image width, one quotient bit a cycle,
// giving the new column and the rows to move down.
// ----------------------------------------------------------------------------
module trle_wrap
  import trle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] x_in,
  input  logic [15:0] y_in,
  input  logic [7:0]  len,
  input  logic [15:0] width,
  output logic        done,
  output logic [15:0] x_out,
  output logic [15:0] y_out
);

  logic        active;
  logic [2:0]  step;
  logic [16:0] rem;
  logic [22:0] dvs;
  logic [7:0]  quo;
  logic [15:0] y_base;
  logic        fits;

  assign fits  = {6'd0, rem} >= dvs;
  assign x_out = rem[15:0];
  assign y_out = y_base + {8'd0, quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= 3'd7;
      end else if (active) begin
        step <= step - 3'd1;
        if (step == 3'd0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= {1'b0, x_in} + {9'd0, len};
      dvs    <= {width, 7'd0};
      quo    <= 8'd0;
      y_base <= y_in;
    end else if (active) begin
      if (fits) begin
        rem <= rem - dvs[16:0];
      end
      quo <= {quo[6:0], fits};
      dvs <= {1'b0, dvs[22:1]};
    end
  end

endmodule

>>> sv/trle_ctrl.sv
// ----------------------------------------------------------------------------
// trle_ctrl: sequencing state machine of the decoder.
// Takes one byte, lets the datapath process it, then hands out the run and
// the closing word in order, waiting on the position update between them.
// ----------------------------------------------------------------------------
module trle_ctrl
  import trle_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  trle_status_t st,
  output trle_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      C_IDLE: begin
        if (s_tvalid) state_next = C_EXEC;
      end
      C_EXEC: state_next = C_ROUTE;
      C_ROUTE: begin
        priority if (st.has_run) state_next = C_EMIT_RUN;
        else if (st.has_tail) state_next = C_EMIT_TAIL;
        else state_next = C_IDLE;
      end
      C_EMIT_RUN: begin
        if (st.out_free) begin
          priority if (st.need_wrap) state_next = C_WRAP;
          else if (st.has_tail) state_next = C_EMIT_TAIL;
          else state_next = C_IDLE;
        end
      end
      C_WRAP: begin
        if (st.wrap_done) state_next = st.has_tail ? C_EMIT_TAIL : C_IDLE;
      end
      C_EMIT_TAIL: begin
        if (st.out_free) state_next = C_IDLE;
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_comb begin
    s_tready       = (state == C_IDLE);
    cmd.take       = (state == C_IDLE) && s_tvalid;
    cmd.exec       = (state == C_EXEC);
    cmd.load_run   = (state == C_EMIT_RUN) && st.out_free;
    cmd.wrap_start = (state == C_EMIT_RUN) && st.out_free && st.need_wrap;
    cmd.load_tail  = (state == C_EMIT_TAIL) && st.out_free;
  end

endmodule

>>> sv/trle_dp.sv
// ----------------------------------------------------------------------------
// trle_dp: decoder datapath.
// Holds the header fields, packet state and pixel position, evaluates one
// byte per exec command, and owns the output word register.
// ----------------------------------------------------------------------------
module trle_dp
  import trle_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  trle_cmd_t              cmd,
  output trle_status_t           st,
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic [7:0]             s_tdata,
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OutDataBits-1:0] m_tdata,
  output logic [1:0]             m_tuser
);

  logic [31:0] budget, data_end;
  logic [7:0]  in_byte;
  logic        in_last;

  phase_t      phase, phase_next;
  logic [31:0] byte_offset, byte_offset_next;
  logic [7:0]  id_length, id_length_next;
  logic [7:0]  image_type, image_type_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic [7:0]  bit_depth, bit_depth_next;
  logic [7:0]  descriptor, descriptor_next;
  logic        cmap_flag, cmap_flag_next;
  logic [31:0] pix_count, pix_count_next;
  logic [31:0] pixels_written, pixels_written_next;
  logic [7:0]  packet_remaining, packet_remaining_next;
  logic        packet_repeated, packet_repeated_next;
  logic [1:0]  channel_index, channel_index_next;
  logic [31:0] colour_bytes, colour_bytes_next;
  logic [15:0] pos_x, pos_y;

  logic        has_run, has_tail, need_wrap;
  logic [15:0] run_x, run_y, run_w;
  logic [7:0]  run_len, run_alpha;
  logic [23:0] run_rgb;
  logic        run_colrev, run_topdown;
  logic [1:0]  tail_kind;
  logic [2:0]  tail_code;

  logic        ev_run, ev_tail;
  logic [1:0]  ev_kind;
  logic [2:0]  ev_code;
  logic [15:0] ev_x, ev_y;
  logic [7:0]  ev_len, ev_alpha;
  logic [31:0] ev_col;

  logic        wrap_done;
  logic [15:0] wrap_x, wrap_y;

  logic [2:0]  chans;
  logic        bp_fail;
  logic [2:0]  bp_code;
  logic [31:0] bo_inc;

  assign chans  = (bit_depth == 8'd32) ? 3'd4 : 3'd3;
  assign bo_inc = (byte_offset == 32'hFFFF_FFFF) ? byte_offset : byte_offset + 32'd1;

  // Checks that open a packet, shared by the header end, the ID end and the packet end.
  always_comb begin
    if (image_type == TYPE_RLE) begin
      bp_fail = bo_inc >= data_end;
      bp_code = ERR_SHORT_PKT;
    end else begin
      bp_fail = ({1'b0, bo_inc} + {30'd0, chans}) > {1'b0, data_end};
      bp_code = ERR_PKT_BOUNDS;
    end
  end

  always_comb begin
    logic        unsup, over, last_pix, rep;
    logic [7:0]  run;
    logic [9:0]  need;
    logic [31:0] col, pw_n;
    logic [7:0]  len, pr_n;
    logic [3:0]  attr;

    phase_next            = phase;
    byte_offset_next      = bo_inc;
    id_length_next        = id_length;
    image_type_next       = image_type;
    width_reg_next        = width_reg;
    height_reg_next       = height_reg;
    bit_depth_next        = bit_depth;
    descriptor_next       = descriptor;
    cmap_flag_next        = cmap_flag;
    pix_count_next        = pix_count;
    pixels_written_next   = pixels_written;
    packet_remaining_next = packet_remaining;
    packet_repeated_next  = packet_repeated;
    channel_index_next    = channel_index;
    colour_bytes_next     = colour_bytes;
    ev_run   = 1'b0;
    ev_tail  = 1'b0;
    ev_kind  = KIND_ERROR;
    ev_code  = ERR_NONE;
    ev_x     = pos_x;
    ev_y     = pos_y;
    ev_len   = 8'd1;
    ev_alpha = 8'hFF;
    ev_col   = 32'd0;
    attr     = in_byte[3:0];
    unsup    = 1'b0;
    over     = 1'b0;
    last_pix = 1'b0;
    rep      = in_byte[7];
    run      = {1'b0, in_byte[6:0]} + 8'd1;
    need     = 10'd0;
    col      = 32'd0;
    pw_n     = pixels_written;
    len      = 8'd1;
    pr_n     = packet_remaining;

    unique case (phase)
      PH_HEADER: begin
        unique case (byte_offset)
          32'd0:  id_length_next = in_byte;
          32'd1:  cmap_flag_next = (in_byte != 8'd0);
          32'd2:  image_type_next = in_byte;
          32'd12: width_reg_next = {8'd0, in_byte};
          32'd13: width_reg_next = {in_byte, width_reg[7:0]};
          32'd14: height_reg_next = {8'd0, in_byte};
          32'd15: height_reg_next = {in_byte, height_reg[7:0]};
          32'd16: begin
            bit_depth_next = in_byte;
            pix_count_next = {16'd0, width_reg} * {16'd0, height_reg};
          end
          32'd17: descriptor_next = in_byte;
          default: ;
        endcase
        if (byte_offset == 32'd17) begin
          unsup = cmap_flag || (image_type != TYPE_RAW && image_type != TYPE_RLE) ||
                  (bit_depth != 8'd24 && bit_depth != 8'd32) || (in_byte[7:6] != 2'd0) ||
                  (attr != 4'd0 && !(bit_depth == 8'd32 && attr == 4'd8));
          over  = (width_reg == 16'd0) || (height_reg == 16'd0) || (budget < 32'd24) ||
                  (pix_count > ((budget - 32'd24) >> 2));
          priority if (unsup) begin
            ev_tail = 1'b1; ev_code = ERR_UNSUPPORTED; phase_next = PH_ERR;
          end else if (over) begin
            ev_tail = 1'b1; ev_code = ERR_BUDGET; phase_next = PH_ERR;
          end else if (({1'b0, 32'(HeaderLen)} + {25'd0, id_length}) > {1'b0, data_end}) begin
            ev_tail = 1'b1; ev_code = ERR_SHORT_ID; phase_next = PH_ERR;
          end else if (id_length != 8'd0) begin
            phase_next = PH_ID;
          end else if (bp_fail) begin
            ev_tail = 1'b1; ev_code = bp_code; phase_next = PH_ERR;
          end else begin
            phase_next = (image_type == TYPE_RLE) ? PH_PKT : PH_PIX;
            packet_remaining_next = 8'd1;
            packet_repeated_next  = 1'b0;
            channel_index_next    = 2'd0;
            colour_bytes_next     = 32'd0;
          end
        end
      end
      PH_ID: begin
        if ({1'b0, bo_inc} >= ({1'b0, 32'(HeaderLen)} + {25'd0, id_length})) begin
          if (bp_fail) begin
            ev_tail = 1'b1; ev_code = bp_code; phase_next = PH_ERR;
          end else begin
            phase_next = (image_type == TYPE_RLE) ? PH_PKT : PH_PIX;
            packet_remaining_next = 8'd1;
            packet_repeated_next  = 1'b0;
            channel_index_next    = 2'd0;
            colour_bytes_next     = 32'd0;
          end
        end
      end
      PH_PKT: begin
        need = rep ? {7'd0, chans} :
               ((chans == 3'd4) ? {run, 2'd0} : ({1'b0, run, 1'b0} + {2'd0, run}));
        if ({24'd0, run} > (pix_count - pixels_written) ||
            ({1'b0, bo_inc} + {23'd0, need}) > {1'b0, data_end}) begin
          ev_tail = 1'b1; ev_code = ERR_PKT_BOUNDS; phase_next = PH_ERR;
        end else begin
          packet_remaining_next = run;
          packet_repeated_next  = rep;
          channel_index_next    = 2'd0;
          colour_bytes_next     = 32'd0;
          phase_next            = PH_PIX;
        end
      end
      PH_PIX: begin
        col      = colour_bytes | ({24'd0, in_byte} << {channel_index, 3'd0});
        last_pix = ({1'b0, channel_index} + 3'd1) >= chans;
        colour_bytes_next = col;
        if (last_pix) begin
          len      = packet_repeated ? packet_remaining : 8'd1;
          ev_run   = 1'b1;
          ev_col   = col;
          ev_len   = len;
          ev_alpha = (bit_depth == 8'd32) ? col[31:24] : 8'hFF;
          ev_x     = descriptor[4] ? (width_reg - 16'd1 - pos_x) : pos_x;
          ev_y     = descriptor[5] ? pos_y : (height_reg - 16'd1 - pos_y);
          pw_n     = pixels_written + {24'd0, len};
          pr_n     = packet_remaining - len;
          pixels_written_next   = pw_n;
          packet_remaining_next = pr_n;
          channel_index_next    = 2'd0;
          colour_bytes_next     = 32'd0;
          if (pr_n == 8'd0) begin
            if (pw_n >= pix_count) begin
              ev_tail = 1'b1; ev_kind = KIND_COMPLETE; phase_next = PH_DONE;
            end else if (bp_fail) begin
              ev_tail = 1'b1; ev_code = bp_code; phase_next = PH_ERR;
            end else begin
              phase_next = (image_type == TYPE_RLE) ? PH_PKT : PH_PIX;
              packet_remaining_next = 8'd1;
              packet_repeated_next  = 1'b0;
            end
          end
        end else begin
          channel_index_next = channel_index + 2'd1;
        end
      end
      PH_DONE, PH_ERR: ;
      default: ;
    endcase

    // The last byte of a file closes any unfinished image with an error.
    if (in_last) begin
      unique case (phase_next)
        PH_HEADER: begin ev_tail = 1'b1; ev_kind = KIND_ERROR; ev_code = ERR_SHORT_HDR; end
        PH_ID:     begin ev_tail = 1'b1; ev_kind = KIND_ERROR; ev_code = ERR_SHORT_ID; end
        PH_PKT:    begin ev_tail = 1'b1; ev_kind = KIND_ERROR; ev_code = ERR_SHORT_PKT; end
        PH_PIX:    begin ev_tail = 1'b1; ev_kind = KIND_ERROR; ev_code = ERR_PKT_BOUNDS; end
        default: ;
      endcase
    end
  end

  trle_wrap u_wrap (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.wrap_start),
    .x_in  (pos_x),
    .y_in  (pos_y),
    .len   (run_len),
    .width (run_w),
    .done  (wrap_done),
    .x_out (wrap_x),
    .y_out (wrap_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      budget   <= 32'hFFFF_FFFF;
      data_end <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BUDGET:   budget   <= cfg_data;
        REG_DATA_END: data_end <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.exec && in_last)) begin
      phase            <= PH_HEADER;
      byte_offset      <= 32'd0;
      id_length        <= 8'd0;
      image_type       <= 8'd0;
      width_reg        <= 16'd0;
      height_reg       <= 16'd0;
      bit_depth        <= 8'd0;
      descriptor       <= 8'd0;
      cmap_flag        <= 1'b0;
      pix_count        <= 32'd0;
      pixels_written   <= 32'd0;
      packet_remaining <= 8'd0;
      packet_repeated  <= 1'b0;
      channel_index    <= 2'd0;
      colour_bytes     <= 32'd0;
      pos_x            <= 16'd0;
      pos_y            <= 16'd0;
    end else if (cmd.exec) begin
      phase            <= phase_next;
      byte_offset      <= byte_offset_next;
      id_length        <= id_length_next;
      image_type       <= image_type_next;
      width_reg        <= width_reg_next;
      height_reg       <= height_reg_next;
      bit_depth        <= bit_depth_next;
      descriptor       <= descriptor_next;
      cmap_flag        <= cmap_flag_next;
      pix_count        <= pix_count_next;
      pixels_written   <= pixels_written_next;
      packet_remaining <= packet_remaining_next;
      packet_repeated  <= packet_repeated_next;
      channel_index    <= channel_index_next;
      colour_bytes     <= colour_bytes_next;
    end else if (wrap_done) begin
      pos_x <= wrap_x;
      pos_y <= wrap_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_run   <= 1'b0;
      has_tail  <= 1'b0;
      need_wrap <= 1'b0;
    end else if (cmd.exec) begin
      has_run   <= ev_run;
      has_tail  <= ev_tail;
      need_wrap <= ev_run && !in_last;
    end else begin
      if (cmd.load_run) has_run <= 1'b0;
      if (cmd.load_tail) has_tail <= 1'b0;
      if (cmd.wrap_start) need_wrap <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      run_x       <= ev_x;
      run_y       <= ev_y;
      run_len     <= ev_len;
      run_rgb     <= ev_col[23:0];
      run_alpha   <= ev_alpha;
      run_colrev  <= descriptor[4];
      run_topdown <= descriptor[5];
      run_w       <= width_reg;
      tail_kind   <= ev_kind;
      tail_code   <= ev_code;
    end
  end

  assign st.has_run   = has_run;
  assign st.has_tail  = has_tail;
  assign st.need_wrap = need_wrap;
  assign st.wrap_done = wrap_done;
  assign st.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_run || cmd.load_tail) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_run) begin
      m_tuser <= KIND_RUN;
      m_tdata <= {3'd0, run_w, run_topdown, run_colrev, run_alpha, run_rgb[7:0],
                  run_rgb[15:8], run_rgb[23:16], run_len, run_y, run_x, ERR_NONE};
    end else if (cmd.load_tail) begin
      m_tuser <= tail_kind;
      m_tdata <= {{(OutDataBits-3){1'b0}}, tail_code};
    end
  end

endmodule

>>> sv/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder: streaming decoder for true-color TGA images.
// Parses the header, skips the image ID and turns raw or RLE BGR(A) pixel
// data into runs of identical RGBA pixels with their destination position.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Word contents
// s_*       in         tdata: data_byte; tlast: last_byte
// m_*       out        tuser: kind; tdata: error code, position, run, color
// cfg_*     in         index 0 decode_budget, index 1 data_end_offset
//
// An input word that yields no result passes through the idle, exec and route
// states. A word that completes a pixel also emits each result word and, unless
// it has tlast set, runs the wrap unit, which divides the new column by the image
// width, one quotient bit a cycle, before the new position is loaded.
// The single output register waits on m_tready and holds the block.
// Reset is synchronous and returns both registers to all ones; a word with
// tlast set rearms the decoder but keeps the registers.
module tga_rle_pixel_decoder
  import trle_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] data_byte
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [2:0] error_code, [18:3] dest_x, [34:19] dest_y, [42:35] run_length,
  // [50:43] red, [58:51] green, [66:59] blue, [74:67] alpha,
  // [75] columns_reversed, [76] rows_top_down, [92:77] image_width, zeros above
  output logic [OutDataBits-1:0] m_tdata,
  output logic [1:0]             m_tuser,   // [1:0] kind
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  trle_cmd_t    cmd;
  trle_status_t st;

  // The controller only sequences; all decoding state lives in the datapath.
  trle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  trle_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // A word is processed alone: the block never takes two in a row.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a word is in process");

  // Run words carry no error code and at least one pixel.
  a_run_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_RUN |-> m_tdata[2:0] == ERR_NONE && m_tdata[42:35] != 8'd0)
    else $error("run word with bad fields");

  // Closing words carry nothing beyond their code.
  a_tail_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_RUN |-> m_tdata[OutDataBits-1:3] == '0)
    else $error("closing word with payload");

endmodule
